FILE: rtl/fnm_pkg.sv
package fnm_pkg;

  localparam int COORD_W   = 12;
  localparam int U_W       = 17;
  localparam int REM_W     = COORD_W + 1;
  localparam int DIV_STEPS = U_W;
  localparam int OCTAVES   = 8;
  localparam int OCT_W     = 4;
  localparam int SUM_W     = 20;
  localparam int FRAC_W    = 16;
  localparam int ROM_DEPTH = 256;
  localparam int ROM_AW    = 8;
  localparam int W_W       = 16;
  localparam int HASH_W    = 31;
  localparam int NOISE_W   = 8;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam logic [COORD_W-1:0] SPAN_RESET = 12'd255;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [0:0] {
    REG_SPAN_X = 1'b0,
    REG_SPAN_Y = 1'b1
  } reg_idx_e;

  typedef logic [W_W-1:0] rom_t [ROM_DEPTH];

  // sin^2 weight table, taylor series in q30
  function automatic rom_t build_rom();
    rom_t r;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] sq;
    logic [63:0] f;
    logic signed [63:0] s;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      th = (PI_Q30 * 64'(i)) / (2 * ROM_DEPTH);
      th2 = (th * th) >> 30;
      term = th;
      s = $signed(th);
      for (int k = 1; k <= 9; k++) begin
        term = (term * th2) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) != 0) begin
          s = s - $signed(term);
        end else begin
          s = s + $signed(term);
        end
      end
      if (s < 0) begin
        s = '0;
      end
      sq = $unsigned(s) * $unsigned(s);
      f = (sq + (64'd1 << 43)) >> 44;
      if (f > 64'd65535) begin
        f = 64'd65535;
      end
      r[i] = W_W'(f);
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  function automatic logic [HASH_W-1:0] hash_seed(input logic [9:0] i, input logic [9:0] j);
    logic [31:0] n;
    n = 32'(i) + 32'd57 * 32'(j);
    return HASH_W'((n << 13) ^ n);
  endfunction

  typedef struct packed {
    logic               valid;
    logic [REM_W-1:0]   rem_x;
    logic [REM_W-1:0]   rem_y;
    logic [U_W-1:0]     q_x;
    logic [U_W-1:0]     q_y;
  } div_bus_t;

  typedef struct packed {
    logic                    valid;
    logic [U_W-1:0]          u;
    logic [U_W-1:0]          v;
    logic signed [SUM_W-1:0] sum;
  } oct_bus_t;

endpackage

FILE: rtl/fnm_div_cell.sv
module fnm_div_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [fnm_pkg::COORD_W-1:0]   span_x_i,
  input  logic [fnm_pkg::COORD_W-1:0]   span_y_i,
  input  fnm_pkg::div_bus_t             bus_i,
  output fnm_pkg::div_bus_t             bus_o
);

  logic                         geq_x, geq_y;
  logic [fnm_pkg::REM_W-1:0]    rx, ry;
  logic                         valid_q;
  fnm_pkg::div_bus_t            bus_d, bus_q;

  // one quotient bit per cell, restoring step
  always_comb begin
    geq_x = bus_i.rem_x >= {1'b0, span_x_i};
    geq_y = bus_i.rem_y >= {1'b0, span_y_i};
    rx = geq_x ? bus_i.rem_x - {1'b0, span_x_i} : bus_i.rem_x;
    ry = geq_y ? bus_i.rem_y - {1'b0, span_y_i} : bus_i.rem_y;
    bus_d.valid = bus_i.valid;
    bus_d.rem_x = {rx[fnm_pkg::REM_W-2:0], 1'b0};
    bus_d.rem_y = {ry[fnm_pkg::REM_W-2:0], 1'b0};
    bus_d.q_x = {bus_i.q_x[fnm_pkg::U_W-2:0], geq_x};
    bus_d.q_y = {bus_i.q_y[fnm_pkg::U_W-2:0], geq_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= bus_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bus_q <= bus_d;
    end
  end

  always_comb begin
    bus_o = bus_q;
    bus_o.valid = valid_q;
  end

endmodule

FILE: rtl/fnm_octave_cell.sv
module fnm_octave_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [fnm_pkg::OCT_W-1:0]   octave_i,
  input  fnm_pkg::oct_bus_t           bus_i,
  output fnm_pkg::oct_bus_t           bus_o
);

  localparam int S_W = fnm_pkg::U_W + fnm_pkg::OCTAVES;
  localparam int P_W = 52;
  localparam int R_W = 34;
  localparam int V_W = 36;
  localparam int STAGES = 9;

  typedef struct packed {
    logic [fnm_pkg::U_W-1:0]          u;
    logic [fnm_pkg::U_W-1:0]          v;
    logic signed [fnm_pkg::SUM_W-1:0] sum;
    logic [fnm_pkg::W_W-1:0]          wx;
    logic [fnm_pkg::W_W-1:0]          wy;
  } carry_t;

  function automatic logic signed [P_W-1:0] tdiv16(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] bias;
    bias = p[P_W-1] ? P_W'(65535) : '0;
    return (p + bias) >>> 16;
  endfunction

  logic [STAGES-1:0]            vld_q;
  carry_t                       c_q [STAGES];
  logic [S_W-1:0]               sx, sy;
  logic [9:0]                   ix, iy;
  logic [fnm_pkg::HASH_W-1:0]   n0_q [4];
  logic [fnm_pkg::HASH_W-1:0]   n1_q [4];
  logic [fnm_pkg::HASH_W-1:0]   n2_q [4];
  logic [fnm_pkg::HASH_W-1:0]   nn1_q [4];
  logic [fnm_pkg::HASH_W-1:0]   t2_q [4];
  logic signed [31:0]           lat3_q [4];
  logic signed [P_W-1:0]        prod4_q [2];
  logic signed [31:0]           lo4_q [2];
  logic signed [R_W-1:0]        r5_q [2];
  logic signed [P_W-1:0]        prod6_q;
  logic signed [R_W-1:0]        r6_q;
  logic signed [V_W-1:0]        val7_q;
  logic [4:0]                   sh;
  logic signed [V_W-1:0]        bias8, contrib8;
  carry_t                       c0_d;

  always_comb begin
    sx = S_W'(bus_i.u) << (octave_i + 1'b1);
    sy = S_W'(bus_i.v) << (octave_i + 1'b1);
    ix = 10'(sx[S_W-1:fnm_pkg::FRAC_W]);
    iy = 10'(sy[S_W-1:fnm_pkg::FRAC_W]);
    c0_d.u = bus_i.u;
    c0_d.v = bus_i.v;
    c0_d.sum = bus_i.sum;
    c0_d.wx = fnm_pkg::COS_ROM[sx[fnm_pkg::FRAC_W-1 -: fnm_pkg::ROM_AW]];
    c0_d.wy = fnm_pkg::COS_ROM[sy[fnm_pkg::FRAC_W-1 -: fnm_pkg::ROM_AW]];
    sh = 5'd14 + 5'(octave_i);
    bias8 = val7_q[V_W-1] ? ((V_W'(1) <<< sh) - V_W'(1)) : '0;
    contrib8 = (val7_q + bias8) >>> sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], bus_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0] <= c0_d;
      for (int s = 1; s < STAGES - 1; s++) begin
        c_q[s] <= c_q[s-1];
      end
      c_q[STAGES-1].u <= c_q[STAGES-2].u;
      c_q[STAGES-1].v <= c_q[STAGES-2].v;
      c_q[STAGES-1].wx <= c_q[STAGES-2].wx;
      c_q[STAGES-1].wy <= c_q[STAGES-2].wy;
      c_q[STAGES-1].sum <= c_q[STAGES-2].sum + fnm_pkg::SUM_W'(contrib8);
      // lattice corners: (ix,iy) (ix+1,iy) (ix,iy+1) (ix+1,iy+1)
      n0_q[0] <= fnm_pkg::hash_seed(ix, iy);
      n0_q[1] <= fnm_pkg::hash_seed(ix + 10'd1, iy);
      n0_q[2] <= fnm_pkg::hash_seed(ix, iy + 10'd1);
      n0_q[3] <= fnm_pkg::hash_seed(ix + 10'd1, iy + 10'd1);
      for (int p = 0; p < 4; p++) begin
        nn1_q[p] <= fnm_pkg::HASH_W'(n0_q[p] * n0_q[p]);
        n1_q[p] <= n0_q[p];
        t2_q[p] <= fnm_pkg::HASH_W'(nn1_q[p] * 31'd15731 + 31'd789221);
        n2_q[p] <= n1_q[p];
        lat3_q[p] <= 32'sd1073741824
                   - $signed({1'b0, fnm_pkg::HASH_W'(n2_q[p] * t2_q[p] + 31'd1376312589)});
      end
      for (int h = 0; h < 2; h++) begin
        prod4_q[h] <= P_W'($signed({lat3_q[2*h+1][31], lat3_q[2*h+1]})
                           - $signed({lat3_q[2*h][31], lat3_q[2*h]}))
                    * P_W'($signed({1'b0, c_q[3].wx}));
        lo4_q[h] <= lat3_q[2*h];
        r5_q[h] <= R_W'(lo4_q[h]) + R_W'(tdiv16(prod4_q[h]));
      end
      prod6_q <= P_W'(35'(r5_q[1]) - 35'(r5_q[0])) * P_W'($signed({1'b0, c_q[5].wy}));
      r6_q <= r5_q[0];
      val7_q <= V_W'(r6_q) + V_W'(tdiv16(prod6_q));
    end
  end

  always_comb begin
    bus_o.valid = vld_q[STAGES-1];
    bus_o.u = c_q[STAGES-1].u;
    bus_o.v = c_q[STAGES-1].v;
    bus_o.sum = c_q[STAGES-1].sum;
  end

endmodule

FILE: rtl/fractal_value_noise_map.sv
// channel   | dir | payload (low bit up)             | handshake
// s_axis    | in  | tdata: pixel_x[11:0] pixel_y[23:12] | tvalid/tready
// m_axis    | out | tdata: noise_byte[7:0]            | tvalid/tready
// apb       | in  | span_x @0x0, span_y @0x4          | psel/penable, pready=1
// one request per cycle unless the chain halts; pipeline: 17 divider cells, 8 octave
// cells of 9 stages, one output register
// the whole chain moves together and halts while a result waits untaken
// reset clears valid bits and sets both spans to 255
module fractal_value_noise_map (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // pixel_x, pixel_y
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // noise_byte
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fnm_pkg::ADDR_W-1:0]    paddr,
  input  logic [fnm_pkg::DATA_W-1:0]    pwdata,
  output logic [fnm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int CW = fnm_pkg::COORD_W;

  logic [CW-1:0]              span_x_q, span_y_q;
  logic [CW-1:0]              px, py;
  logic                       en;
  logic                       wr;
  fnm_pkg::reg_idx_e          idx;
  fnm_pkg::div_bus_t          div_bus [fnm_pkg::DIV_STEPS+1];
  fnm_pkg::oct_bus_t          oct_bus [fnm_pkg::OCTAVES+1];
  logic signed [fnm_pkg::SUM_W-1:0] tot;
  logic [17:0]                biased;
  logic [25:0]                scaled;
  logic                       out_vld_q;
  logic [fnm_pkg::NOISE_W-1:0] noise_q;

  assign pready = 1'b1;
  assign idx = fnm_pkg::reg_idx_e'(paddr[2]);
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_x_q <= fnm_pkg::SPAN_RESET;
      span_y_q <= fnm_pkg::SPAN_RESET;
    end else if (wr) begin
      case (idx)
        fnm_pkg::REG_SPAN_X: span_x_q <= pwdata[CW-1:0];
        fnm_pkg::REG_SPAN_Y: span_y_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fnm_pkg::REG_SPAN_X: prdata = {(fnm_pkg::DATA_W-CW)'(0), span_x_q};
      fnm_pkg::REG_SPAN_Y: prdata = {(fnm_pkg::DATA_W-CW)'(0), span_y_q};
      default:             prdata = '0;
    endcase
  end

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    px = (s_axis_tdata[CW-1:0] > span_x_q) ? span_x_q : s_axis_tdata[CW-1:0];
    py = (s_axis_tdata[2*CW-1:CW] > span_y_q) ? span_y_q : s_axis_tdata[2*CW-1:CW];
    div_bus[0].valid = s_axis_tvalid;
    div_bus[0].rem_x = {1'b0, px};
    div_bus[0].rem_y = {1'b0, py};
    div_bus[0].q_x = '0;
    div_bus[0].q_y = '0;
  end

  for (genvar g = 0; g < fnm_pkg::DIV_STEPS; g++) begin : g_div
    fnm_div_cell u_div (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .span_x_i (span_x_q),
      .span_y_i (span_y_q),
      .bus_i    (div_bus[g]),
      .bus_o    (div_bus[g+1])
    );
  end

  // zero span gives coordinate zero
  always_comb begin
    oct_bus[0].valid = div_bus[fnm_pkg::DIV_STEPS].valid;
    oct_bus[0].u = (span_x_q == '0) ? '0 : div_bus[fnm_pkg::DIV_STEPS].q_x;
    oct_bus[0].v = (span_y_q == '0) ? '0 : div_bus[fnm_pkg::DIV_STEPS].q_y;
    oct_bus[0].sum = '0;
  end

  for (genvar g = 0; g < fnm_pkg::OCTAVES; g++) begin : g_oct
    fnm_octave_cell u_oct (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .octave_i (fnm_pkg::OCT_W'(g)),
      .bus_i    (oct_bus[g]),
      .bus_o    (oct_bus[g+1])
    );
  end

  always_comb begin
    tot = oct_bus[fnm_pkg::OCTAVES].sum;
    if (tot > 20'sd65536) begin
      tot = 20'sd65536;
    end else if (tot < -20'sd65536) begin
      tot = -20'sd65536;
    end
    biased = 18'(tot + 20'sd65536);
    scaled = 26'(biased) * 26'd255;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= oct_bus[fnm_pkg::OCTAVES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      noise_q <= scaled[24:17];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = noise_q;

  a_stall_keeps_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> out_vld_q)
    else $error("result dropped while stalled");

  a_stall_keeps_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> $stable(noise_q))
    else $error("result changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while chain halted");

endmodule

FILE: test/noise_checker.sv
module noise_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // pixel_x, pixel_y
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [7:0]                        m_axis_tdata,  // noise_byte
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fnm_pkg::ADDR_W-1:0]        paddr,
  input  logic [fnm_pkg::DATA_W-1:0]        pwdata,
  input  logic                              pready,
  output int                                fail_count,
  output int                                pending_count
);

  localparam longint unsigned PI_FIX = 64'd3373259426;

  logic [15:0] weight_rom [256];
  logic [11:0] span_x_q;
  logic [11:0] span_y_q;
  logic [7:0]  expected_noise [$];
  int          fails;

  assign fail_count    = fails;
  assign pending_count = expected_noise.size();

  // sin^2 blend weights
  initial begin
    longint unsigned th, th2, term, sq, f;
    longint          s;
    for (int i = 0; i < 256; i++) begin
      th = PI_FIX * longint'(i) / 64'd512;
      th2 = (th * th) >> 30;
      term = th;
      s = longint'(th);
      for (int k = 1; k <= 9; k++) begin
        term = (term * th2) >> 30;
        term = term / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          s = s - longint'(term);
        end else begin
          s = s + longint'(term);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      sq = longint'(s) * longint'(s);
      f = (sq + (64'd1 << 43)) >> 44;
      if (f > 64'd65535) begin
        f = 64'd65535;
      end
      weight_rom[i] = f[15:0];
    end
  end

  function automatic longint corner_value(logic [31:0] i, logic [31:0] j);
    logic [31:0] n;
    logic [31:0] m;
    n = i + 32'd57 * j;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return (longint'(1) << 30) - longint'(m);
  endfunction

  function automatic longint cos_mix(longint a, longint b, logic [15:0] frac);
    longint w;
    w = longint'(weight_rom[frac[15:8]]);
    return a + (b - a) * w / 65536;
  endfunction

  function automatic logic [16:0] scale_coord(logic [11:0] p, logic [11:0] span);
    logic [11:0] pc;
    logic [31:0] q;
    pc = (p > span) ? span : p;
    if (span == 0) begin
      return '0;
    end
    q = {pc, 16'h0000} / {20'h0, span};
    return q[16:0];
  endfunction

  function automatic logic [7:0] noise_of(logic [11:0] px, logic [11:0] py);
    logic [16:0] u;
    logic [16:0] v;
    logic [31:0] sx, sy, ix, iy;
    longint      r0, r1, val, total, mapped;
    u = scale_coord(px, span_x_q);
    v = scale_coord(py, span_y_q);
    total = 0;
    for (int k = 0; k < 8; k++) begin
      sx = {15'h0, u} << (k + 1);
      sy = {15'h0, v} << (k + 1);
      ix = sx >> 16;
      iy = sy >> 16;
      r0 = cos_mix(corner_value(ix, iy), corner_value(ix + 1, iy), sx[15:0]);
      r1 = cos_mix(corner_value(ix, iy + 1), corner_value(ix + 1, iy + 1), sx[15:0]);
      val = cos_mix(r0, r1, sy[15:0]);
      total += val / (longint'(1) << (14 + k));
    end
    if (total > 65536) begin
      total = 65536;
    end
    if (total < -65536) begin
      total = -65536;
    end
    mapped = ((65536 + total) * 255) >>> 17;
    return mapped[7:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_x_q <= fnm_pkg::SPAN_RESET;
      span_y_q <= fnm_pkg::SPAN_RESET;
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (fnm_pkg::reg_idx_e'(paddr[2]) == fnm_pkg::REG_SPAN_X) begin
          span_x_q <= pwdata[11:0];
        end else begin
          span_y_q <= pwdata[11:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_noise.push_back(noise_of(s_axis_tdata[11:0], s_axis_tdata[23:12]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_noise.size() == 0) begin
          report_mismatch($sformatf("unexpected noise_byte %0d", m_axis_tdata));
        end else if (m_axis_tdata !== expected_noise[0]) begin
          report_mismatch($sformatf("noise_byte %0d, wanted %0d", m_axis_tdata,
                                    expected_noise[0]));
          void'(expected_noise.pop_front());
        end else begin
          void'(expected_noise.pop_front());
        end
      end
    end
  end

endmodule

FILE: test/testbench.sv
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [fnm_pkg::ADDR_W-1:0] paddr;
  logic [fnm_pkg::DATA_W-1:0] pwdata;
  logic [fnm_pkg::DATA_W-1:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_count;
  bit          steady;
  bit          hold_long;
  logic [11:0] cur_span_x;
  logic [11:0] cur_span_y;

  fractal_value_noise_map dut (.*);

  noise_checker checker_inst (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("testbench: FAIL");
    $finish;
  end

  // output side back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_long = 1'b0;
        m_axis_tready = 1'b1;
      end else if (!steady && $urandom_range(0, 6) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic write_span(fnm_pkg::reg_idx_e idx, logic [11:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {20'($urandom_range(0, 1048575)), value};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == fnm_pkg::REG_SPAN_X) begin
      cur_span_x = value;
    end else begin
      cur_span_y = value;
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    if (!steady && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function automatic logic [11:0] pick_coord(logic [11:0] span);
    if ($urandom_range(0, 3) == 0 || span == 0) begin
      return 12'($urandom_range(0, 4095));
    end
    return 12'($urandom_range(0, span));
  endfunction

  task automatic random_pixels(int count);
    for (int n = 0; n < count; n++) begin
      send_pixel(pick_coord(cur_span_x), pick_coord(cur_span_y));
    end
  endtask

  initial begin
    logic [11:0] spans [7][2];
    spans = '{'{12'd0, 12'd0}, '{12'd4095, 12'd4095}, '{12'd1, 12'd4095},
              '{12'd4095, 12'd1}, '{12'd7, 12'd3}, '{12'd640, 12'd479},
              '{12'd255, 12'd255}};
    steady = 1'b0;
    hold_long = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_span_x = fnm_pkg::SPAN_RESET;
    cur_span_y = fnm_pkg::SPAN_RESET;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corners, clamping beyond the span, lattice edges
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd255, 12'd255);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd128, 12'd128);
    send_pixel(12'd1, 12'd254);
    send_pixel(12'd256, 12'd3);
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);
    drain();
    write_span(fnm_pkg::REG_SPAN_X, 12'd0);
    write_span(fnm_pkg::REG_SPAN_Y, 12'd4095);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd2048);
    send_pixel(12'd17, 12'd4094);
    hold_long = 1'b1;
    random_pixels(60);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_span(fnm_pkg::REG_SPAN_X, spans[p][0]);
      write_span(fnm_pkg::REG_SPAN_Y, spans[p][1]);
      if (p == 5) begin
        write_span(fnm_pkg::REG_SPAN_X, 12'($urandom_range(0, 4095)));
        write_span(fnm_pkg::REG_SPAN_Y, 12'($urandom_range(0, 4095)));
      end
      steady = (p == 6);
      random_pixels(90);
      drain();
    end

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
